[hdl/brr_pkg.sv]
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types and constants for the BRR block decoder.
// ----------------------------------------------------------------------------
package brr_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned NibWidth    = 4;
   localparam int unsigned HistWidth   = 15;
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned PosWidth    = 4;
   localparam int unsigned ShiftWidth  = 4;
   localparam int unsigned FilterWidth = 2;

   // block layout: header then eight data bytes
   localparam logic [PosWidth-1:0]   PosHeader   = 4'd0;
   localparam logic [PosWidth-1:0]   PosLastData = 4'd8;
   localparam logic [ShiftWidth-1:0] MaxShift    = 4'd12;

   // prediction filter codes
   localparam logic [FilterWidth-1:0] FiltNone   = 2'd0;
   localparam logic [FilterWidth-1:0] FiltOne    = 2'd1;
   localparam logic [FilterWidth-1:0] FiltTwo    = 2'd2;
   localparam logic [FilterWidth-1:0] FiltThree  = 2'd3;

   // filter coefficients
   localparam int unsigned CoefA = 15;
   localparam int unsigned CoefB = 61;
   localparam int unsigned CoefC = 115;
   localparam int unsigned CoefD = 13;

   localparam logic signed [HistWidth-1:0] HistMin = -15'sd16384;
   localparam logic signed [HistWidth-1:0] HistMax = 15'sd16383;

   typedef logic signed [HistWidth-1:0] hist_type;

   // one beat on the result channel
   typedef struct packed {
      logic signed [SampleWidth-1:0] decoded_sample;
      logic                          last_of_pair;
      logic                          bad_shift;
   } rsp_item_type;

endpackage

[hdl/brr_sample_calc.sv]
// ----------------------------------------------------------------------------
// brr_sample_calc
// One nibble to one clamped 15-bit sample: scale, predict, clamp.
// ----------------------------------------------------------------------------
module brr_sample_calc
   import brr_pkg::*;
(
   input  logic [NibWidth-1:0]    nibble,
   input  logic [ShiftWidth-1:0]  shift,
   input  logic [FilterWidth-1:0] filter,
   input  hist_type               p1,
   input  hist_type               p2,
   output hist_type               sample
);

   localparam int unsigned SumWidth = 22;

   // divide by 2^k, truncating toward zero
   function automatic logic signed [SumWidth-1:0] div_trunc(
      input logic signed [SumWidth-1:0] v,
      input logic [2:0]                 k
   );
      logic signed [SumWidth-1:0] bias;
      bias = v[SumWidth-1] ? ((22'sd1 <<< k) - 22'sd1) : 22'sd0;
      return (v + bias) >>> k;
   endfunction

   logic signed [SumWidth-1:0] nib_ext;
   logic signed [SumWidth-1:0] scaled;
   logic signed [SumWidth-1:0] p1_ext;
   logic signed [SumWidth-1:0] p2_ext;
   logic signed [SumWidth-1:0] pred;
   logic signed [SumWidth-1:0] total;

   assign nib_ext = {{(SumWidth-NibWidth){nibble[NibWidth-1]}}, nibble};
   assign p1_ext  = {{(SumWidth-HistWidth){p1[HistWidth-1]}}, p1};
   assign p2_ext  = {{(SumWidth-HistWidth){p2[HistWidth-1]}}, p2};

   // scale then floor-halve
   assign scaled = (nib_ext <<< shift) >>> 1;

   always_comb begin
      case (filter)
         FiltOne: begin
            pred = div_trunc(p1_ext * SumWidth'(CoefA), 3'd4);
         end
         FiltTwo: begin
            pred = div_trunc(p1_ext * SumWidth'(CoefB), 3'd5)
                 - div_trunc(p2_ext * SumWidth'(CoefA), 3'd4);
         end
         FiltThree: begin
            pred = div_trunc(p1_ext * SumWidth'(CoefC), 3'd6)
                 - div_trunc(p2_ext * SumWidth'(CoefD), 3'd4);
         end
         default: begin
            pred = '0;
         end
      endcase
   end

   assign total = scaled + pred;

   always_comb begin
      if (total < SumWidth'(HistMin)) begin
         sample = HistMin;
      end else if (total > SumWidth'(HistMax)) begin
         sample = HistMax;
      end else begin
         sample = total[HistWidth-1:0];
      end
   end

endmodule

[hdl/brr_result_reg.sv]
// ----------------------------------------------------------------------------
// brr_result_reg
// Output register on the result channel; frees itself on the beat it is taken.
// ----------------------------------------------------------------------------
module brr_result_reg
   import brr_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  rsp_item_type                  load_item,
   output logic                          slot_free,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SampleWidth-1:0] rsp_decoded_sample,
   output logic                          rsp_last_of_pair,
   output logic                          rsp_bad_shift
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_decoded_sample = item_ff.decoded_sample;
   assign rsp_last_of_pair   = item_ff.last_of_pair;
   assign rsp_bad_shift      = item_ff.bad_shift;

endmodule

[hdl/brr_adpcm_block_decoder_unit.sv]
// ----------------------------------------------------------------------------
// brr_adpcm_block_decoder_unit
// BRR block decoder: 9-byte blocks in, 16-bit PCM samples out.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one stream byte per beat plus new_sample, which marks the
//    first header of a sample and clears history, block position and mute.
//  - rsp channel: one decoded sample per beat. A data byte gives two beats,
//    high nibble first (last_of_pair low, then high). A header gives none,
//    unless its shift exceeds 12: then one beat with bad_shift high and a zero
//    sample, and the stream is muted until the next new_sample.
//  - Path: a data byte is registered in the input register, and each of its
//    samples then in the result register, high nibble first.
//  - Input register: a data byte holds it until both nibbles are done, since
//    its second nibble predicts from the first; a header or muted byte frees it
//    as soon as it is handled.
//  - req_stall rises while the held byte cannot finish this cycle: in the
//    high-nibble cycle of every data byte, and while the result register is
//    full and stalled and a beat is due.
//  - Reset (synchronous) empties both registers and clears history, position,
//    shift, filter and mute.
// ----------------------------------------------------------------------------
module brr_adpcm_block_decoder_unit
   import brr_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // byte channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ByteWidth-1:0]          req_stream_byte,
   input  logic                          req_new_sample,
   // sample channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SampleWidth-1:0] rsp_decoded_sample,
   output logic                          rsp_last_of_pair,
   output logic                          rsp_bad_shift
);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_new_ff;

   // decoder state
   hist_type             newest_ff, newest_in;
   hist_type             older_ff, older_in;
   logic [PosWidth-1:0]  pos_ff, pos_in;
   logic [ShiftWidth-1:0] shift_ff, shift_in;
   logic [FilterWidth-1:0] filter_ff, filter_in;
   logic                 failed_ff, failed_in;
   logic                 phase_ff, phase_in;   // high: low nibble next

   logic                 req_take;
   logic                 eff_failed;
   logic [PosWidth-1:0]  eff_pos;
   logic                 is_header;
   logic                 hdr_bad;
   logic                 need_out;
   logic                 go;
   logic                 step_done;
   logic                 emit;
   rsp_item_type         emit_item;
   logic                 slot_free;
   logic [NibWidth-1:0]  cur_nibble;
   hist_type             calc_sample;

   // fresh only ever arrives on a header, so clears need not reach the calc
   assign eff_failed = failed_ff && !in_new_ff;
   assign eff_pos    = in_new_ff ? PosHeader : pos_ff;
   assign is_header  = (eff_pos == PosHeader) || (eff_pos > PosLastData);
   assign hdr_bad    = in_byte_ff[7:4] > MaxShift;
   assign need_out   = !eff_failed && (!is_header || hdr_bad);
   assign go         = in_valid_ff && (!need_out || slot_free);

   assign cur_nibble = phase_ff ? in_byte_ff[3:0] : in_byte_ff[7:4];

   brr_sample_calc u_calc (
      .nibble (cur_nibble),
      .shift  (shift_ff),
      .filter (filter_ff),
      .p1     (newest_ff),
      .p2     (older_ff),
      .sample (calc_sample)
   );

   always_comb begin
      newest_in = newest_ff;
      older_in  = older_ff;
      pos_in    = pos_ff;
      shift_in  = shift_ff;
      filter_in = filter_ff;
      failed_in = failed_ff;
      phase_in  = phase_ff;
      step_done = 1'b0;
      emit      = 1'b0;
      emit_item = '0;
      if (go) begin
         step_done = 1'b1;
         if (in_new_ff) begin
            newest_in = '0;
            older_in  = '0;
            pos_in    = PosHeader;
            failed_in = 1'b0;
         end
         if (eff_failed) begin
            // muted: byte dropped
         end else if (is_header) begin
            shift_in  = in_byte_ff[7:4];
            filter_in = in_byte_ff[3:2];
            if (hdr_bad) begin
               failed_in           = 1'b1;
               pos_in              = PosHeader;
               emit                = 1'b1;
               emit_item.bad_shift = 1'b1;
            end else begin
               pos_in = 4'd1;
            end
         end else begin
            emit                     = 1'b1;
            emit_item.decoded_sample = {calc_sample, 1'b0};
            emit_item.last_of_pair   = phase_ff;
            newest_in                = calc_sample;
            older_in                 = newest_ff;
            if (!phase_ff) begin
               phase_in  = 1'b1;
               step_done = 1'b0;
            end else begin
               phase_in = 1'b0;
               pos_in   = (pos_ff >= PosLastData) ? PosHeader : PosWidth'(pos_ff + 4'd1);
            end
         end
      end
   end

   assign req_stall   = in_valid_ff && !step_done;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !step_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         newest_ff   <= '0;
         older_ff    <= '0;
         pos_ff      <= PosHeader;
         shift_ff    <= '0;
         filter_ff   <= FiltNone;
         failed_ff   <= 1'b0;
         phase_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         newest_ff   <= newest_in;
         older_ff    <= older_in;
         pos_ff      <= pos_in;
         shift_ff    <= shift_in;
         filter_ff   <= filter_in;
         failed_ff   <= failed_in;
         phase_ff    <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_stream_byte;
         in_new_ff  <= req_new_sample;
      end
   end

   brr_result_reg u_result (
      .clock              (clock),
      .reset              (reset),
      .load               (emit),
      .load_item          (emit_item),
      .slot_free          (slot_free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decoded_sample (rsp_decoded_sample),
      .rsp_last_of_pair   (rsp_last_of_pair),
      .rsp_bad_shift      (rsp_bad_shift)
   );

   // low nibble phase only with a byte held
   a_phase_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> in_valid_ff)
      else $error("low nibble phase without a held byte");

   // block position never leaves the header/data range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosLastData)
      else $error("block position out of range");

   // a muted stream waits for a header
   a_mute_pos: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (pos_ff == PosHeader && !phase_ff))
      else $error("muted stream not at header position");

   // error beats carry a zero sample
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_shift) |-> (rsp_decoded_sample == '0 && !rsp_last_of_pair))
      else $error("error beat with sample data");

   // the first nibble is always followed by the second
   a_pair: assert property (@(posedge clock) disable iff (reset)
      (go && !phase_ff && !is_header && !eff_failed) |=> phase_ff)
      else $error("second nibble not scheduled");

endmodule

[test/brr_adpcm_block_decoder_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brr_adpcm_block_decoder_unit_tb
// Self-checking bench for the BRR block decoder.
// A byte queue feeds a burst/gap driver. A model of the decoder built into the
// bench predicts every sample beat at the point where a byte is taken, and the
// monitor compares each sample beat against the oldest prediction. The
// receiver stalls on patterns that change from time to time.
// ----------------------------------------------------------------------------
module brr_adpcm_block_decoder_unit_tb;
   import brr_pkg::*;

   localparam int unsigned ClockPeriod = 20;
   localparam int unsigned CycleLimit  = 500000;
   localparam int unsigned RandomBytes = 1850;
   localparam int unsigned DrainCycles = 10;

   typedef struct packed {
      logic [ByteWidth-1:0] stream_byte;
      logic                 new_sample;
   } byte_beat_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [ByteWidth-1:0]          req_stream_byte = '0;
   logic                          req_new_sample = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SampleWidth-1:0] rsp_decoded_sample;
   logic                          rsp_last_of_pair;
   logic                          rsp_bad_shift;

   brr_adpcm_block_decoder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .req_new_sample     (req_new_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decoded_sample (rsp_decoded_sample),
      .rsp_last_of_pair   (rsp_last_of_pair),
      .rsp_bad_shift      (rsp_bad_shift)
   );

   // stimulus and prediction stores
   byte_beat_type pending_bytes[$];
   rsp_item_type  due_samples[$];

   // decoder model state, mirrors the block's own registers
   int                     hist_newest = 0;
   int                     hist_older  = 0;
   logic [PosWidth-1:0]    blk_pos     = PosHeader;
   logic [ShiftWidth-1:0]  blk_shift   = '0;
   logic [FilterWidth-1:0] blk_filter  = FiltNone;
   bit                     muted       = 1'b0;

   // bookkeeping
   int  mismatch_count = 0;
   int  bytes_taken    = 0;
   int  samples_seen   = 0;
   int  bad_beats      = 0;
   int  headers_taken  = 0;
   int  cycle_count    = 0;
   bit  byte_taken     = 1'b0;

   // driver and receiver pacing
   int            burst_left  = 0;
   int            gap_left    = 0;
   int            stall_left  = 0;
   int            stall_mode  = 0;
   logic [7:0]    stall_bits  = '0;
   byte_beat_type next_beat;
   rsp_item_type  want;

   // -------------------------------------------------------------------------
   // clock and the one reset at the start of the run
   // -------------------------------------------------------------------------
   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // -------------------------------------------------------------------------
   // model: one nibble through shift, filter and clamp
   // -------------------------------------------------------------------------
   function automatic int predict_nibble(input logic [NibWidth-1:0] nib);
      int n;
      int p1;
      int p2;
      p1 = hist_newest;
      p2 = hist_older;
      n  = int'($signed(nib));
      n  = n * (1 << blk_shift);
      n  = n >>> 1;                      // halve, rounding toward minus infinity
      case (blk_filter)
         FiltOne: begin
            n += (p1 * int'(CoefA)) / 16;
         end
         FiltTwo: begin
            n += (p1 * int'(CoefB)) / 32;
            n -= (p2 * int'(CoefA)) / 16;
         end
         FiltThree: begin
            n += (p1 * int'(CoefC)) / 64;
            n -= (p2 * int'(CoefD)) / 16;
         end
         default: begin
         end
      endcase
      if (n < int'(HistMin)) n = int'(HistMin);
      if (n > int'(HistMax)) n = int'(HistMax);
      hist_older  = hist_newest;
      hist_newest = n;
      return n * 2;
   endfunction

   // model: a taken byte, queueing whatever sample beats it causes
   task automatic decode_beat(input logic [ByteWidth-1:0] b, input logic fresh);
      rsp_item_type item;
      if (fresh) begin
         hist_newest = 0;
         hist_older  = 0;
         blk_pos     = PosHeader;
         muted       = 1'b0;
      end
      if (muted) return;
      if (blk_pos == PosHeader || blk_pos > PosLastData) begin
         headers_taken++;
         blk_shift  = b[7:4];
         blk_filter = b[3:2];
         if (blk_shift > MaxShift) begin
            // rejected header: one flagged zero beat, then silence
            muted               = 1'b1;
            blk_pos             = PosHeader;
            item.decoded_sample = '0;
            item.last_of_pair   = 1'b0;
            item.bad_shift      = 1'b1;
            due_samples.push_back(item);
         end else begin
            blk_pos = 4'd1;
         end
      end else begin
         item.bad_shift      = 1'b0;
         item.last_of_pair   = 1'b0;
         item.decoded_sample = SampleWidth'(predict_nibble(b[7:4]));
         due_samples.push_back(item);
         item.last_of_pair   = 1'b1;
         item.decoded_sample = SampleWidth'(predict_nibble(b[3:0]));
         due_samples.push_back(item);
         blk_pos = (blk_pos >= PosLastData) ? PosHeader : blk_pos + 4'd1;
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // -------------------------------------------------------------------------
   // driver: bursts of bytes with random gaps, new byte only once taken
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            next_beat = pending_bytes.pop_front();
            req_stream_byte <= next_beat.stream_byte;
            req_new_sample  <= next_beat.new_sample;
            req_valid       <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 4))
                  0, 1:    gap_left = 0;                    // back-to-back bursts
                  2, 3:    gap_left = $urandom_range(1, 3);
                  default: gap_left = $urandom_range(5, 25);
               endcase
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // receiver: stall pattern switches between none, light, heavy and fixed
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
            stall_bits = 8'($urandom_range(0, 255));
         end
         stall_left--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= stall_bits[3'(stall_left % 8)];
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // monitor: check sample beats first, then predict from the byte taken on
   // the same edge (its own beats cannot leave before the next edge)
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         byte_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            samples_seen++;
            if (rsp_bad_shift) bad_beats++;
            if (due_samples.size() == 0) begin
               report_mismatch($sformatf("sample beat with none due: sample %0d last %0b bad %0b",
                                         rsp_decoded_sample, rsp_last_of_pair, rsp_bad_shift));
            end else begin
               want = due_samples.pop_front();
               if (rsp_decoded_sample !== want.decoded_sample)
                  report_mismatch($sformatf("decoded_sample %0d, want %0d",
                                            rsp_decoded_sample, want.decoded_sample));
               if (rsp_last_of_pair !== want.last_of_pair)
                  report_mismatch($sformatf("last_of_pair %0b, want %0b",
                                            rsp_last_of_pair, want.last_of_pair));
               if (rsp_bad_shift !== want.bad_shift)
                  report_mismatch($sformatf("bad_shift %0b, want %0b",
                                            rsp_bad_shift, want.bad_shift));
            end
         end
         byte_taken = req_valid && !req_stall;
         if (byte_taken) begin
            bytes_taken++;
            decode_beat(req_stream_byte, req_new_sample);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("brr_adpcm_block_decoder_unit test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // stimulus: directed corners, then mostly well-formed samples
   // -------------------------------------------------------------------------
   task automatic add_byte(input logic [ByteWidth-1:0] b, input logic fresh);
      byte_beat_type beat;
      beat.stream_byte = b;
      beat.new_sample  = fresh;
      pending_bytes.push_back(beat);
   endtask

   initial begin
      int unsigned stim_count;
      int unsigned nblocks;
      int unsigned nbytes;
      logic [3:0]  shift_pick;
      logic [7:0]  hdr;
      bit          broke;

      // zero shift, no filter, nibble extremes
      add_byte(8'h00, 1'b1);
      add_byte(8'h7F, 1'b0);
      add_byte(8'h80, 1'b0);
      // largest legal shift, ignored header bits set; nibble extremes of both signs
      add_byte(8'hC3, 1'b1);
      add_byte(8'h78, 1'b0);
      add_byte(8'h87, 1'b0);
      // shift of 13 rejected, later bytes and a header ignored while muted
      add_byte(8'hD0, 1'b1);
      add_byte(8'h12, 1'b0);
      add_byte(8'hC4, 1'b0);
      // shift of 15 rejected straight after a fresh start
      add_byte(8'hF3, 1'b1);
      // filter three driven into the upper clamp, then swung down
      add_byte(8'hCC, 1'b1);
      repeat (4) add_byte(8'h77, 1'b0);
      add_byte(8'h88, 1'b0);
      // filter two
      add_byte(8'hB8, 1'b1);
      add_byte(8'h7F, 1'b0);
      add_byte(8'h80, 1'b0);
      // filter one, then a fresh start in the middle of a block
      add_byte(8'h54, 1'b1);
      add_byte(8'hF0, 1'b0);
      add_byte(8'h0F, 1'b0);
      add_byte(8'hA5, 1'b1);
      add_byte(8'h3C, 1'b0);

      stim_count = 0;
      while (stim_count < RandomBytes) begin
         case ($urandom_range(0, 9))
            8: begin
               // truncated block, cut short by the next fresh start
               add_byte({4'($urandom_range(0, 12)), 4'($urandom_range(0, 15))}, 1'b1);
               nbytes = $urandom_range(0, 7);
               repeat (nbytes) add_byte(8'($urandom_range(0, 255)), 1'b0);
               stim_count += nbytes + 1;
            end
            9: begin
               // noise: any byte, fresh start now and then
               nbytes = $urandom_range(1, 6);
               repeat (nbytes) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
               stim_count += nbytes;
            end
            default: begin
               // well-formed sample of whole blocks
               nblocks = $urandom_range(1, 4);
               broke   = 1'b0;
               for (int unsigned k = 0; k < nblocks && !broke; k++) begin
                  if ($urandom_range(0, 19) == 0)
                     shift_pick = 4'($urandom_range(13, 15));
                  else
                     shift_pick = 4'($urandom_range(0, 12));
                  hdr = {shift_pick, 4'($urandom_range(0, 15))};
                  add_byte(hdr, k == 0);
                  stim_count++;
                  if (shift_pick > MaxShift) begin
                     // muted tail, not counted
                     repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
                     broke = 1'b1;
                  end else begin
                     repeat (8) add_byte(8'($urandom_range(0, 255)), 1'b0);
                     stim_count += 8;
                  end
               end
            end
         endcase
      end

      @(negedge reset);
      // everything handed over, taken and answered
      while (pending_bytes.size() != 0 || req_valid || due_samples.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("run covered %0d stream bytes (%0d headers) and %0d sample beats, %0d of them",
               bytes_taken, headers_taken, samples_seen, bad_beats);
      $display("rejected-shift beats, under bursty input and changing output stalls");
      if (mismatch_count == 0) begin
         $display("brr_adpcm_block_decoder_unit test passed");
      end else begin
         $display("brr_adpcm_block_decoder_unit test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/brr_pkg.sv
hdl/brr_sample_calc.sv
hdl/brr_result_reg.sv
hdl/brr_adpcm_block_decoder_unit.sv
test/brr_adpcm_block_decoder_unit_tb.sv
